/* rtl/assert_macros.svh */
// Assertion macros shared by the oscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define WOM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define WOM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`endif

/* rtl/wom_pkg.sv */
// Shared types and constants of the wavetable oscillator.
`timescale 1ns / 1ps
package wom_pkg;
    localparam int unsigned PHASE_W   = 14;
    localparam int unsigned LEN_W     = 9;
    localparam int unsigned DVD_W     = 28;
    localparam int unsigned DVS_W     = 15;
    localparam int unsigned RECIP_W   = 29;
    localparam int unsigned STEP_SHIFT = 28;
    localparam logic [DVS_W-1:0] SAMPLE_RATE_HZ = 15'd14303;
    // Rounded-up reciprocal of the sample rate scaled by the phase span; exact
    // for every 14-bit frequency with this shift.
    localparam logic [RECIP_W-1:0] STEP_RECIP =
        RECIP_W'(((64'd1 << (PHASE_W + STEP_SHIFT)) + 64'(SAMPLE_RATE_HZ) - 64'd1)
                 / 64'(SAMPLE_RATE_HZ));
    localparam logic [DVD_W-1:0] PHASE_SPAN     = 28'd16384;
    localparam logic signed [10:0] DUTY_OFFSET  = 11'sd130;
    localparam logic signed [10:0] DUTY_TOP     = 11'sd255;
    localparam logic signed [10:0] DUTY_FLOOR   = 11'sd2;

    localparam logic CFG_TABLE_LENGTH = 1'b0;
    localparam logic CFG_INTERP_EN    = 1'b1;
    localparam logic CMD_WRITE        = 1'b0;
    localparam logic CMD_TICK         = 1'b1;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_STEP     = 4'd2;
    localparam logic [3:0] OP_PHASE    = 4'd3;
    localparam logic [3:0] OP_RD_A     = 4'd4;
    localparam logic [3:0] OP_RD_B     = 4'd5;
    localparam logic [3:0] OP_CAP_B    = 4'd6;
    localparam logic [3:0] OP_DIV_Q1   = 4'd7;
    localparam logic [3:0] OP_DIST     = 4'd8;
    localparam logic [3:0] OP_DIV_GAP  = 4'd9;
    localparam logic [3:0] OP_GAP      = 4'd10;
    localparam logic [3:0] OP_MUL      = 4'd11;
    localparam logic [3:0] OP_DIV_NUM  = 4'd12;
    localparam logic [3:0] OP_ACC      = 4'd13;
    localparam logic [3:0] OP_OUT      = 4'd14;

    typedef struct packed {
        logic [3:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic last_voice;
        logic out_full;
    } t_dp_status;
endpackage

/* rtl/wom_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wom_div
    import wom_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);
    localparam int unsigned CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DVS_W:0]   r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   shifted;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        shifted = {r_rem[DVS_W-1:0], r_q[DVD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = shifted - {1'b0, r_dvs};
                n_q   = {r_q[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_q   = {r_q[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    `WOM_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy)
    `WOM_ASSERT_NXT(a_last_done, i_clk, i_rst_n, r_busy && !i_start && r_cnt == CNT_LAST, r_done && !r_busy)
endmodule

/* rtl/wom_ctrl.sv */
// Sequencer that steps the datapath through one tick, voice by voice.
`timescale 1ns / 1ps
module wom_ctrl
    import wom_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_cmd,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_STEP  = 4'd1;
    localparam logic [3:0] S_PHASE = 4'd2;
    localparam logic [3:0] S_RDA   = 4'd3;
    localparam logic [3:0] S_RDB   = 4'd4;
    localparam logic [3:0] S_CAPB  = 4'd5;
    localparam logic [3:0] S_Q1    = 4'd6;
    localparam logic [3:0] S_DIST  = 4'd7;
    localparam logic [3:0] S_GAP   = 4'd8;
    localparam logic [3:0] S_GAPC  = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;
    localparam logic [3:0] S_NUM   = 4'd11;
    localparam logic [3:0] S_ACC   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;
    localparam logic [3:0] S_WAIT  = 4'd14;

    logic [3:0] r_state, n_state;
    logic [3:0] r_ret, n_ret;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_cmd == CMD_TICK) n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.op = OP_STEP;
                n_state  = S_PHASE;
            end
            S_PHASE: begin o_cmd.op = OP_PHASE; n_state = S_RDA; end
            S_RDA:   begin o_cmd.op = OP_RD_A;  n_state = S_RDB; end
            S_RDB:   begin o_cmd.op = OP_RD_B;  n_state = S_CAPB; end
            S_CAPB:  begin o_cmd.op = OP_CAP_B; n_state = S_Q1; end
            S_Q1: begin
                o_cmd.op = OP_DIV_Q1;
                n_ret    = S_DIST;
                n_state  = S_WAIT;
            end
            S_DIST: begin o_cmd.op = OP_DIST; n_state = S_GAP; end
            S_GAP: begin
                o_cmd.op = OP_DIV_GAP;
                n_ret    = S_GAPC;
                n_state  = S_WAIT;
            end
            S_GAPC: begin o_cmd.op = OP_GAP; n_state = S_MUL; end
            S_MUL:  begin o_cmd.op = OP_MUL; n_state = S_NUM; end
            S_NUM: begin
                o_cmd.op = OP_DIV_NUM;
                n_ret    = S_ACC;
                n_state  = S_WAIT;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = i_status.last_voice ? S_OUT : S_STEP;
            end
            S_OUT: begin
                if (!i_status.out_full) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            S_WAIT: begin
                if (i_status.div_done) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
endmodule

/* rtl/wom_dpath.sv */
// Datapath: wave table, voice phases, shared divider and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wom_dpath
    import wom_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned NUM_VOICES  = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd_bus,
    output t_dp_status          o_status,
    input  logic                i_cmd,
    input  logic [7:0]          i_table_index,
    input  logic signed [7:0]   i_table_value,
    input  logic [PHASE_W-1:0]  i_freq_a,
    input  logic [PHASE_W-1:0]  i_freq_b,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [LEN_W-1:0]    i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [8:0]   o_mixed_sample,
    output logic [7:0]          o_pwm_duty
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int unsigned SW = 14;
    localparam int unsigned PW = PHASE_W + RECIP_W;

    logic [LEN_W-1:0]   r_tlen;
    logic               r_interp;
    logic [LEN_W-1:0]   len;
    logic signed [7:0]  r_mem [TABLE_DEPTH];
    logic signed [7:0]  r_rdata;
    logic [PHASE_W-1:0] r_phase [NUM_VOICES];
    logic [PHASE_W-1:0] r_freq_a, r_freq_b;
    logic [PHASE_W-1:0] r_step;
    logic [VW-1:0]      r_voice;
    logic [PHASE_W-1:0] r_ph;
    logic [LEN_W-1:0]   r_pos;
    logic signed [7:0]  r_a, r_b;
    logic signed [15:0] r_dist;
    logic [DVS_W-1:0]   r_gap;
    logic signed [25:0] r_num;
    logic signed [SW-1:0] r_sum;
    logic               r_out_valid;
    logic signed [8:0]  r_mixed;
    logic [7:0]         r_duty;

    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   quot;

    logic [PHASE_W-1:0] step_freq;
    logic [PW-1:0]      step_prod;
    logic [PHASE_W-1:0] ph_next;
    logic [22:0]        ph_prod;
    logic [LEN_W-1:0]   pos_raw, pos_next, nxt;
    logic [AW-1:0]      rd_addr;
    logic signed [16:0] wa;
    logic signed [25:0] num_next;
    logic [25:0]        num_mag;
    logic signed [10:0] interp_smp, voice_smp;
    logic signed [SW-1:0] sum_sat;
    logic signed [8:0]  mixed_next;
    logic signed [10:0] duty_raw;
    logic [7:0]         duty_next;
    logic               wr_en;

    // Clamp the configured length into 1..TABLE_DEPTH.
    always_comb begin
        len = r_tlen;
        if (r_tlen == '0) len = LEN_W'(1);
        if (32'(r_tlen) > TABLE_DEPTH) len = LEN_W'(TABLE_DEPTH);
    end

    always_comb begin
        // Phase step: frequency times the scaled reciprocal of the sample rate.
        step_freq = (r_voice == '0) ? r_freq_a : r_freq_b;
        step_prod = PW'(step_freq) * PW'(STEP_RECIP);
        ph_next  = r_phase[r_voice] + r_step;
        ph_prod  = 23'(ph_next) * 23'(len);
        pos_raw  = ph_prod[22:14];
        pos_next = (pos_raw >= len) ? len - 1'b1 : pos_raw;
        nxt      = ((r_pos + 1'b1) >= len) ? '0 : r_pos + 1'b1;
        rd_addr  = (i_cmd_bus.op == OP_RD_B) ? AW'(nxt) : AW'(r_pos);
        wa       = $signed({2'b0, r_gap}) - 17'(r_dist);
        num_next = 26'(r_a) * 26'(wa) + 26'(r_b) * 26'(r_dist);
        num_mag  = r_num[25] ? 26'(-r_num) : 26'(r_num);
        interp_smp = r_num[25] ? -$signed({1'b0, quot[9:0]}) : $signed({1'b0, quot[9:0]});
        voice_smp  = r_interp ? interp_smp : 11'(r_a);
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd   = PHASE_SPAN;
        div_dvs   = DVS_W'(len);
        case (i_cmd_bus.op)
            OP_DIV_Q1: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({r_pos, 14'b0});
            end
            OP_DIV_GAP: div_start = 1'b1;
            OP_DIV_NUM: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(num_mag);
                div_dvs   = r_gap;
            end
            default: div_start = 1'b0;
        endcase
    end

    wom_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Saturate the voice sum, then derive the duty.
    always_comb begin
        sum_sat = r_sum;
        if (r_sum > SW'(255)) sum_sat = SW'(255);
        if (r_sum < -SW'(256)) sum_sat = -SW'(256);
        mixed_next = sum_sat[8:0];
        duty_raw   = 11'(mixed_next) + DUTY_OFFSET;
        if (duty_raw > DUTY_TOP) duty_raw = DUTY_TOP;
        if (duty_raw <= 11'sd0) duty_raw = DUTY_FLOOR;
        duty_next = duty_raw[7:0];
    end

    assign wr_en = (i_cmd_bus.op == OP_LOAD) && (i_cmd == CMD_WRITE)
                   && (32'(i_table_index) < TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[AW'(i_table_index)] <= i_table_value;
        if (i_cmd_bus.op == OP_RD_A || i_cmd_bus.op == OP_RD_B) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen      <= LEN_W'(256);
            r_interp    <= 1'b1;
            r_out_valid <= 1'b0;
            r_voice     <= '0;
            for (int v = 0; v < NUM_VOICES; v++) r_phase[v] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_TABLE_LENGTH) r_tlen <= i_cfg_data;
                else r_interp <= i_cfg_data[0];
            end
            if (i_cmd_bus.op == OP_OUT) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (i_cmd_bus.op == OP_LOAD) r_voice <= '0;
            if (i_cmd_bus.op == OP_ACC) r_voice <= r_voice + 1'b1;
            if (i_cmd_bus.op == OP_PHASE) r_phase[r_voice] <= ph_next;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd_bus.op)
            OP_LOAD: begin
                r_freq_a <= i_freq_a;
                r_freq_b <= i_freq_b;
                r_sum    <= '0;
            end
            OP_STEP:  r_step <= step_prod[STEP_SHIFT +: PHASE_W];
            OP_PHASE: begin
                r_ph  <= ph_next;
                r_pos <= pos_next;
            end
            OP_RD_B:  r_a    <= r_rdata;
            OP_CAP_B: r_b    <= r_rdata;
            OP_DIST:  r_dist <= $signed({2'b0, r_ph}) - $signed({1'b0, quot[DVS_W-1:0]});
            OP_GAP:   r_gap  <= quot[DVS_W-1:0];
            OP_MUL:   r_num  <= num_next;
            OP_ACC:   r_sum  <= r_sum + SW'(voice_smp);
            OP_OUT: begin
                r_mixed <= mixed_next;
                r_duty  <= duty_next;
            end
            default: r_sum <= r_sum;
        endcase
    end

    assign o_status.div_done   = div_done;
    assign o_status.last_voice = (r_voice == VW'(NUM_VOICES - 1));
    assign o_status.out_full   = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_mixed_sample = r_mixed;
    assign o_pwm_duty     = r_duty;

    `WOM_ASSERT_NXT(a_pos_in_range, i_clk, i_rst_n, i_cmd_bus.op == OP_PHASE, r_pos < len)
    `WOM_ASSERT_IMP(a_out_no_overrun, i_clk, i_rst_n, i_cmd_bus.op == OP_OUT, !(r_out_valid && i_out_stall))
endmodule

/* rtl/wavetable_oscillator_mixer.sv */
// Top level of the two-voice wavetable oscillator and mixer.
`timescale 1ns / 1ps
// Each transfer on the input channel is either a table write or a sample tick.
// A write stores one signed 8-bit entry and yields no result. A tick advances
// every voice's 14-bit phase, looks up one entry, or with interpolation
// enabled linearly blends two adjacent entries, sums the voices and yields one
// result: the saturated sum and a PWM duty of sum plus 130, clamped to at most
// 255, with a duty at or below zero set to 2. A tick is accepted, then each
// voice in turn does a phase step (a reciprocal multiply by the sample rate), a
// table lookup, three divisions in one shared 28-bit restoring divider (one
// quotient bit per cycle) and the blend and sum, and finally the output register
// is loaded, which waits only while a full output register is stalled.
// The finished result sits in an output register, so the next
// tick is taken while it waits. Write table_length and interpolate_enable only
// while the block is idle; entries must be written before any tick reads them.
module wavetable_oscillator_mixer
    import wom_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned NUM_VOICES  = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [7:0]         i_table_index,
    input  logic signed [7:0]  i_table_value,
    input  logic [13:0]        i_freq_a,
    input  logic [13:0]        i_freq_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [8:0]  o_mixed_sample,
    output logic [7:0]         o_pwm_duty,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [8:0]         i_cfg_data
);
    t_dp_cmd    cmd_bus;
    t_dp_status status;

    // Sequence one tick: the controller issues at most one datapath operation per state.
    wom_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd_bus)
    );

    // Hold the table, phases, divider and the output register.
    wom_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_VOICES  (NUM_VOICES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_bus      (cmd_bus),
        .o_status       (status),
        .i_cmd          (i_cmd),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .i_freq_a       (i_freq_a),
        .i_freq_b       (i_freq_b),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mixed_sample (o_mixed_sample),
        .o_pwm_duty     (o_pwm_duty)
    );
endmodule

/* bench/tb_wavetable_oscillator_mixer.sv */
// Self-checking testbench for the two-voice wavetable oscillator and mixer.
`timescale 1ns / 1ps
module tb_wavetable_oscillator_mixer
    import wom_pkg::*;
();

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE_CYCLES = 400;
    localparam int LONG_HOLD    = 3000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 100;

    typedef struct {
        logic              cmd;
        logic [7:0]        index;
        logic signed [7:0] value;
        logic [13:0]       freq_a;
        logic [13:0]       freq_b;
        bit                typed;      // expected result given in the row
        logic signed [8:0] mix;
        logic [7:0]        duty;
    } t_row;

    typedef struct {
        logic signed [8:0] mix;
        logic [7:0]        duty;
    } t_mix_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_cmd;
    logic [7:0]        i_table_index;
    logic signed [7:0] i_table_value;
    logic [13:0]       i_freq_a;
    logic [13:0]       i_freq_b;
    logic              o_out_valid;
    logic              i_out_stall;
    logic signed [8:0] o_mixed_sample;
    logic [7:0]        o_pwm_duty;
    logic              i_cfg_we;
    logic              i_cfg_addr;
    logic [8:0]        i_cfg_data;

    // Predictor state: its own copy of the table, phases and registers.
    logic signed [7:0] model_table [256];
    logic [13:0]       model_phase [2];
    logic [8:0]        model_length;
    logic              model_interp;

    t_mix_result pending_mix [$];
    int          error_count;
    int          cycle_count;
    bit          calm;
    bit          hold_req;
    bit          hold_taken;
    int          hold_cnt;
    int          stall_burst;

    wavetable_oscillator_mixer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .i_freq_a       (i_freq_a),
        .i_freq_b       (i_freq_b),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mixed_sample (o_mixed_sample),
        .o_pwm_duty     (o_pwm_duty),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Advance one voice and return its sample, blended when interpolation is on.
    function automatic int voice_level(int v, logic [13:0] freq);
        int len, step, ph, pos, offset, gap, a, b, nxt, wa, wb;
        len = (model_length == 0) ? 1 : ((model_length > 256) ? 256 : int'(model_length));
        step = (int'(freq) * 16384) / 14303;
        ph = (int'(model_phase[v]) + step) & 16383;
        model_phase[v] = ph[13:0];
        pos = (ph * len) / 16384;
        if (pos >= len) pos = len - 1;
        a = model_table[pos];
        if (!model_interp) return a;
        offset = ph - (pos * 16384) / len;
        gap = 16384 / len;
        nxt = pos + 1;
        if (nxt >= len) nxt -= len;
        b = model_table[nxt];
        wa = gap - offset;
        wb = gap - wa;
        return (a * wa + b * wb) / gap;
    endfunction

    function automatic t_mix_result mix_voices(logic [13:0] fa, logic [13:0] fb);
        t_mix_result r;
        int sum, duty;
        sum = voice_level(0, fa) + voice_level(1, fb);
        if (sum > 255) sum = 255;
        if (sum < -256) sum = -256;
        duty = sum + 130;
        if (duty > 255) duty = 255;
        if (duty <= 0) duty = 2;
        r.mix = sum[8:0];
        r.duty = duty[7:0];
        return r;
    endfunction

    // Offer one item, hold it until the transfer, then update the predictor.
    task automatic send_item(t_row row, bit allow_gap);
        t_mix_result r;
        int gap;
        if (allow_gap && !calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= row.cmd;
        i_table_index <= row.index;
        i_table_value <= row.value;
        i_freq_a      <= row.freq_a;
        i_freq_b      <= row.freq_b;
        do @(posedge i_clk); while (o_in_stall);
        if (row.cmd == CMD_WRITE) begin
            model_table[row.index] = row.value;
        end else begin
            r = mix_voices(row.freq_a, row.freq_b);
            if (row.typed) begin
                r.mix = row.mix;
                r.duty = row.duty;
            end
            pending_mix.push_back(r);
        end
    endtask

    // Drop valid and wait for every expected result.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_mix.size() != 0);
    endtask

    // Drain, let any write in flight finish, then write both registers.
    task automatic set_config(logic [8:0] length, logic interp);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_TABLE_LENGTH;
        i_cfg_data <= length;
        @(posedge i_clk);
        model_length = length;
        i_cfg_addr <= CFG_INTERP_EN;
        i_cfg_data <= {8'd0, interp};
        @(posedge i_clk);
        model_interp = interp;
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_row write_row(logic [7:0] idx, logic signed [7:0] val);
        t_row row;
        row = '{cmd: CMD_WRITE, index: idx, value: val, freq_a: 14'($urandom),
                freq_b: 14'($urandom), typed: 1'b0, mix: '0, duty: '0};
        return row;
    endfunction

    function automatic t_row tick_row(logic [13:0] fa, logic [13:0] fb);
        t_row row;
        row = '{cmd: CMD_TICK, index: 8'($urandom), value: 8'($urandom), freq_a: fa,
                freq_b: fb, typed: 1'b0, mix: '0, duty: '0};
        return row;
    endfunction

    function automatic t_row typed_tick(logic signed [8:0] mix, logic [7:0] duty);
        t_row row;
        row = tick_row(14'd0, 14'd0);
        row.typed = 1'b1;
        row.mix = mix;
        row.duty = duty;
        return row;
    endfunction

    function automatic logic [13:0] pick_freq();
        case ($urandom_range(0, 4))
            0: return 14'($urandom_range(0, 200));
            1: return 14'd16383;
            2: return 14'd0;
            default: return 14'($urandom_range(0, 16383));
        endcase
    endfunction

    // Directed rows run on a one-entry table without interpolation, so the
    // extremes can be read straight off: both voices return entry zero.
    t_row directed [13];
    initial begin
        directed[0]  = write_row(8'd0, 8'sd127);
        directed[1]  = typed_tick(9'sd254, 8'd255);     // duty clamps at the top
        directed[2]  = write_row(8'd0, -8'sd128);
        directed[3]  = typed_tick(-9'sd256, 8'd2);      // duty at or below zero
        directed[4]  = write_row(8'd0, 8'sd0);
        directed[5]  = typed_tick(9'sd0, 8'd130);
        directed[6]  = write_row(8'd0, 8'sd1);
        directed[7]  = tick_row(14'd16383, 14'd16383);
        directed[8]  = write_row(8'd255, -8'sd128);     // top index, never read here
        directed[9]  = write_row(8'd255, 8'sd127);
        directed[10] = tick_row(14'd1, 14'd0);
        directed[11] = write_row(8'd0, -8'sd66);
        directed[12] = typed_tick(-9'sd132, 8'd2);
    end

    logic [8:0] phase_len    [NUM_PHASES] = '{9'd256, 9'd256, 9'd0, 9'd511,
                                              9'd3, 9'd100, 9'd1, 9'd0};
    logic       phase_interp [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1,
                                              1'b1, 1'b0, 1'b1, 1'b1};

    // Main stimulus sequence.
    initial begin
        t_row row;
        logic [8:0] len;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_WRITE;
        i_table_index = '0;
        i_table_value = '0;
        i_freq_a      = '0;
        i_freq_b      = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_TABLE_LENGTH;
        i_cfg_data    = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        error_count   = 0;
        model_phase[0] = '0;
        model_phase[1] = '0;
        model_length  = 9'd256;
        model_interp  = 1'b1;
        foreach (model_table[i]) model_table[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(9'd1, 1'b0);
        foreach (directed[i]) send_item(directed[i], 1'b1);

        // Load every entry so no later tick can read an unwritten one.
        set_config(9'd256, 1'b1);
        for (int i = 0; i < 256; i++)
            send_item(write_row(8'(i), 8'($urandom)), 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            len = (p == NUM_PHASES - 1) ? 9'($urandom_range(2, 255)) : phase_len[p];
            set_config(len, phase_interp[p]);
            if (p == 2) hold_req = 1'b1;   // receiver holds off while items keep coming
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == NUM_PHASES - 1 && k >= PHASE_ITEMS - 60) calm = 1'b1;
                if (p == 4 && k == PHASE_ITEMS / 2) wait_drained();
                if ($urandom_range(0, 99) < 25)
                    row = write_row(8'($urandom), 8'($urandom));
                else
                    row = tick_row(pick_freq(), pick_freq());
                send_item(row, 1'b1);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_mix.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver: random stall bursts plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cnt    <= 0;
            hold_taken  <= 1'b0;
            stall_burst <= 0;
        end else begin
            if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
            end else if (hold_req && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_cnt   <= LONG_HOLD;
            end
            if (stall_burst != 0) begin
                stall_burst <= stall_burst - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_burst <= $urandom_range(1, 14);
            end
            i_out_stall <= (hold_cnt != 0) || (stall_burst != 0);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_mix_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_mix.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result mix=%0d duty=%0d", $realtime,
                         o_mixed_sample, o_pwm_duty);
            end else begin
                want = pending_mix.pop_front();
                if (o_mixed_sample !== want.mix) begin
                    error_count++;
                    $display("%0t: mixed_sample expected %0d actual %0d", $realtime,
                             want.mix, o_mixed_sample);
                end
                if (o_pwm_duty !== want.duty) begin
                    error_count++;
                    $display("%0t: pwm_duty expected %0d actual %0d", $realtime,
                             want.duty, o_pwm_duty);
                end
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule

/* files.f */
+incdir+rtl
rtl/wom_pkg.sv
rtl/wom_div.sv
rtl/wom_ctrl.sv
rtl/wom_dpath.sv
rtl/wavetable_oscillator_mixer.sv
bench/tb_wavetable_oscillator_mixer.sv
